// ===== rtl/core/fdds_pkg.sv =====
// ----------------------------------------------------------------------------
// fdds_pkg
// Shared types and constants for the four-digit display scanner.
// ----------------------------------------------------------------------------
package fdds_pkg;

  // item field widths
  localparam int VALUE_W  = 14;
  localparam int DOT_W    = 3;
  localparam int BCD_W    = 4;
  localparam int DWELL_W  = 16;

  // a loaded value splits into this many decimal digits
  localparam int SPLIT_DIGITS = 4;

  localparam logic [VALUE_W-1:0] VALUE_LIMIT = 14'd10000;
  localparam logic [DOT_W-1:0]   NO_DOT      = 3'd4;
  localparam logic [DWELL_W-1:0] DWELL_RESET = 16'd3;

  // reciprocal multipliers for constant division, exact for 14-bit values
  localparam logic [15:0] RECIP_10    = 16'd52429;
  localparam int          SHIFT_10    = 19;
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int          SHIFT_100   = 19;
  localparam logic [13:0] RECIP_1000  = 14'd8389;
  localparam int          SHIFT_1000  = 23;

  // configuration port
  localparam int APB_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_DWELL = 1'b0;

  // item kinds
  typedef enum logic {
    MODE_TICK = 1'b0,
    MODE_LOAD = 1'b1
  } mode_t;

  typedef logic [BCD_W-1:0] bcd_t;
  typedef bcd_t [SPLIT_DIGITS-1:0] bcd_split_t;

endpackage

// ===== rtl/core/fdds_if.sv =====
// ----------------------------------------------------------------------------
// fdds_if
// Valid/ready channels for load/tick items and display result items.
// ----------------------------------------------------------------------------
interface fdds_in_if;
  import fdds_pkg::*;

  logic               valid;
  logic               ready;
  logic               mode;
  logic [VALUE_W-1:0] value;
  logic [DOT_W-1:0]   dot_place;

  modport source (output valid, output mode, output value, output dot_place, input ready);
  modport sink   (input valid, input mode, input value, input dot_place, output ready);
endinterface

interface fdds_out_if #(parameter int DIGIT_COUNT = 4);
  import fdds_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [DIGIT_COUNT-1:0] digit_select;
  logic [BCD_W-1:0]       bcd_code;
  logic                   dot_on;
  logic                   rejected;

  modport source (output valid, output digit_select, output bcd_code, output dot_on,
                  output rejected, input ready);
  modport sink   (input valid, input digit_select, input bcd_code, input dot_on,
                  input rejected, output ready);
endinterface

// ===== rtl/core/four_digit_display_scanner.sv =====
// ----------------------------------------------------------------------------
// four_digit_display_scanner
// Multiplexed BCD display scanner with dwell timer and APB register.
// ----------------------------------------------------------------------------
// Each item on in_chan is either a time tick (mode 0) or a load (mode 1). A
// load with a value below 10000 is split into decimal digits (digit 0 holds
// the ones) and stored with its dot position; any other value changes nothing
// and comes back with rejected set. After dwell_ticks ticks the scan moves to
// the next digit, wrapping after DIGIT_COUNT digits; a dwell of 0 acts as 1.
// Every item returns one result item with the active-low digit select, the
// BCD code and the dot line of the current digit, taken after the item is
// applied. An item passes the input register, then the result register, and
// one item is taken every cycle; throughput is limited only by out_chan.ready.
// dwell_ticks is the only register, at byte address 0, reset value 3; it is
// written only while the block is idle, a rule the block leaves to the user.
module four_digit_display_scanner #(
  parameter int DIGIT_COUNT = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  fdds_in_if.sink                           in_chan,
  fdds_out_if.source                        out_chan,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fdds_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [fdds_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [fdds_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import fdds_pkg::*;

  localparam int IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

  // input register
  logic               s1_valid_r, s1_valid_nxt;
  logic               s1_mode_r;
  logic [VALUE_W-1:0] s1_value_r;
  logic [DOT_W-1:0]   s1_dot_r;

  // display state
  bcd_t               digit_r   [DIGIT_COUNT];
  bcd_t               digit_nxt [DIGIT_COUNT];
  logic [DOT_W-1:0]   dot_r, dot_nxt;
  logic [IDX_W-1:0]   scan_r, scan_nxt;
  logic [DWELL_W-1:0] dwell_cnt_r, dwell_cnt_nxt;
  logic [DWELL_W-1:0] dwell_ticks_r;

  // result register
  logic                   out_valid_r, out_valid_nxt;
  logic [DIGIT_COUNT-1:0] out_sel_r, out_sel_nxt;
  bcd_t                   out_bcd_r, out_bcd_nxt;
  logic                   out_dot_r, out_dot_nxt;
  logic                   out_rej_r, out_rej_nxt;

  // handshake and helpers
  logic               out_free;
  logic               s1_go;
  logic               in_take;
  logic               in_range;
  logic               scan_last;
  logic [DWELL_W:0]   dwell_inc;
  logic [DWELL_W-1:0] dwell_limit;
  logic               cfg_write;
  logic               cfg_hit;
  bcd_split_t         split_digits;
  bcd_t               load_digit [DIGIT_COUNT];

  // ---------------------------------------------------------------------------
  // flow control: the result register frees when empty or taken, the input
  // register moves on whenever the result register frees
  // ---------------------------------------------------------------------------
  assign out_free      = !out_valid_r || out_chan.ready;
  assign s1_go         = s1_valid_r && out_free;
  assign in_chan.ready = !s1_valid_r || out_free;
  assign in_take       = in_chan.valid && in_chan.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // decimal split of the registered load value
  // ---------------------------------------------------------------------------
  fdds_bcd_split u_split (
    .value  (s1_value_r),
    .digits (split_digits)
  );

  // digits past the thousands are always zero
  for (genvar g = 0; g < DIGIT_COUNT; g++) begin : g_load
    if (g < SPLIT_DIGITS) begin : g_dec
      assign load_digit[g] = split_digits[g];
    end else begin : g_zero
      assign load_digit[g] = '0;
    end
  end

  assign in_range    = s1_value_r < VALUE_LIMIT;
  assign dwell_inc   = {1'b0, dwell_cnt_r} + 1'b1;
  assign dwell_limit = (dwell_ticks_r == '0) ? DWELL_W'(1) : dwell_ticks_r;
  assign scan_last   = ({1'b0, scan_r} == (IDX_W + 1)'(DIGIT_COUNT - 1));

  // ---------------------------------------------------------------------------
  // state update for the item in the input register
  // ---------------------------------------------------------------------------
  always_comb begin
    digit_nxt     = digit_r;
    dot_nxt       = dot_r;
    scan_nxt      = scan_r;
    dwell_cnt_nxt = dwell_cnt_r;
    out_rej_nxt   = 1'b0;
    if (s1_go) begin
      if (s1_mode_r == MODE_LOAD) begin
        // a load leaves the scan and the dwell timer alone
        if (in_range) begin
          digit_nxt = load_digit;
          dot_nxt   = s1_dot_r;
        end else begin
          out_rej_nxt = 1'b1;
        end
      end else begin
        if (dwell_inc >= {1'b0, dwell_limit}) begin
          dwell_cnt_nxt = '0;
          scan_nxt      = scan_last ? '0 : IDX_W'(scan_r + 1'b1);
        end else begin
          dwell_cnt_nxt = dwell_inc[DWELL_W-1:0];
        end
      end
    end
  end

  // result fields come from the state after the item
  always_comb begin
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      out_sel_nxt[i] = (scan_nxt != IDX_W'(i));
    end
    out_bcd_nxt = digit_nxt[scan_nxt];
    out_dot_nxt = (dot_nxt == DOT_W'(scan_nxt));
  end

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      dot_r       <= NO_DOT;
      scan_r      <= '0;
      dwell_cnt_r <= '0;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        digit_r[i] <= '0;
      end
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      dot_r       <= dot_nxt;
      scan_r      <= scan_nxt;
      dwell_cnt_r <= dwell_cnt_nxt;
      digit_r     <= digit_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_mode_r  <= in_chan.mode;
      s1_value_r <= in_chan.value;
      s1_dot_r   <= in_chan.dot_place;
    end
    if (s1_go) begin
      out_sel_r <= out_sel_nxt;
      out_bcd_r <= out_bcd_nxt;
      out_dot_r <= out_dot_nxt;
      out_rej_r <= out_rej_nxt;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.digit_select = out_sel_r;
  assign out_chan.bcd_code     = out_bcd_r;
  assign out_chan.dot_on       = out_dot_r;
  assign out_chan.rejected     = out_rej_r;

  // ---------------------------------------------------------------------------
  // configuration port: register index sits above the byte offset
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_hit   = (paddr[CFG_ADDR_W-1:2] == CFG_IDX_DWELL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dwell_ticks_r <= DWELL_RESET;
    end else if (cfg_write && cfg_hit) begin
      dwell_ticks_r <= pwdata[DWELL_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (cfg_hit) begin
      prdata = APB_DATA_W'(dwell_ticks_r);
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, scan_r} < (IDX_W + 1)'(DIGIT_COUNT))
    else $error("scan index out of range");

  a_load_holds_scan: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && (s1_mode_r == MODE_LOAD) |=> $stable(scan_r) && $stable(dwell_cnt_r))
    else $error("load moved the scan");

  a_tick_not_rejected: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && (s1_mode_r == MODE_TICK) |=> !out_rej_r)
    else $error("tick flagged as rejected");

  a_one_digit_lit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $countones(~out_sel_r) == 1)
    else $error("digit select not one-cold");

  a_reject_keeps_digits: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && (s1_mode_r == MODE_LOAD) && !in_range |=> $stable(dot_r))
    else $error("rejected load changed the dot");

endmodule

// ===== rtl/core/fdds_bcd_split.sv =====
// ----------------------------------------------------------------------------
// fdds_bcd_split
// Splits a binary value below 10000 into four decimal digits.
// ----------------------------------------------------------------------------
module fdds_bcd_split (
  input  logic [fdds_pkg::VALUE_W-1:0] value,
  output fdds_pkg::bcd_split_t         digits
);
  import fdds_pkg::*;

  logic [29:0]        prod_10;
  logic [26:0]        prod_100;
  logic [27:0]        prod_1000;
  logic [10:0]        quo_10;
  logic [7:0]         quo_100;
  logic [4:0]         quo_1000;
  logic [VALUE_W-1:0] rem_1;
  logic [VALUE_W-1:0] rem_10;
  logic [VALUE_W-1:0] rem_100;

  // three independent quotients, each a constant multiply and shift
  assign prod_10   = 30'(value) * 30'(RECIP_10);
  assign prod_100  = 27'(value) * 27'(RECIP_100);
  assign prod_1000 = 28'(value) * 28'(RECIP_1000);

  assign quo_10   = prod_10[SHIFT_10 +: 11];
  assign quo_100  = prod_100[SHIFT_100 +: 8];
  assign quo_1000 = prod_1000[SHIFT_1000 +: 5];

  // digit k = floor(v / 10^k) - 10 * floor(v / 10^(k+1))
  assign rem_1   = value - VALUE_W'(quo_10) * VALUE_W'(10);
  assign rem_10  = VALUE_W'(quo_10) - VALUE_W'(quo_100) * VALUE_W'(10);
  assign rem_100 = VALUE_W'(quo_100) - VALUE_W'(quo_1000) * VALUE_W'(10);

  assign digits[0] = rem_1[BCD_W-1:0];
  assign digits[1] = rem_10[BCD_W-1:0];
  assign digits[2] = rem_100[BCD_W-1:0];
  assign digits[3] = quo_1000[BCD_W-1:0];

endmodule

// ===== dv/four_digit_display_scanner_tb.sv =====
// ----------------------------------------------------------------------------
// four_digit_display_scanner_tb
// Self-checking bench for the multiplexed four-digit BCD display scanner.
// ----------------------------------------------------------------------------
// Load and tick items are sent over the input channel. A local model of the
// scanner predicts the result item for each item that is accepted. Every
// result that comes back is compared field by field with the oldest
// prediction. The dwell register is written over APB between phases, while
// the block is idle. Traffic runs with no idling, then with a mostly idle
// sender, then with a mostly stalling receiver, then with both.
module four_digit_display_scanner_tb;
  import fdds_pkg::*;

  localparam int DIGITS      = 4;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASE_ITEMS = 440;
  localparam int CHUNKS      = 4;
  localparam int MAX_REPORTS = 40;

  // second register slot, not implemented, writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 1'b1;

  typedef struct packed {
    logic [DIGITS-1:0] digit_select;
    bcd_t              bcd_code;
    logic              dot_on;
    logic              rejected;
  } display_t;

  logic clk;
  logic rst_n;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  fdds_in_if                            in_chan ();
  fdds_out_if #(.DIGIT_COUNT(DIGITS))   out_chan ();

  four_digit_display_scanner #(.DIGIT_COUNT(DIGITS)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // scanner model state
  bcd_t             shown_digits [DIGITS];
  logic [DOT_W-1:0] shown_dot;
  int unsigned      scan_pos;
  int unsigned      dwell_elapsed;
  logic [DWELL_W-1:0] dwell_setting;

  // predicted result items, oldest first
  display_t display_q[$];
  display_t oldest_display;

  // traffic shaping, percentages per cycle
  int send_idle_pct;
  int recv_stall_pct;
  int hold_len;

  int errors;
  int items_sent;
  int results_seen;
  int loads_stored;
  int loads_rejected;
  int dwell_writes;
  int cycle_count;

  // 12 unit period
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_count, display_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic void model_reset();
    for (int i = 0; i < DIGITS; i++) shown_digits[i] = '0;
    shown_dot     = NO_DOT;
    scan_pos      = 0;
    dwell_elapsed = 0;
    dwell_setting = DWELL_RESET;
  endfunction

  // applies one item to the model and returns the display it leaves behind
  function automatic display_t predict_display(input mode_t mode,
                                               input logic [VALUE_W-1:0] value,
                                               input logic [DOT_W-1:0] dot);
    display_t    res;
    int unsigned rest;
    int unsigned dwell_limit;
    res.rejected = 1'b0;
    if (mode == MODE_LOAD) begin
      if (value < VALUE_LIMIT) begin
        // split into decimal digits, ones first
        rest = value;
        for (int i = 0; i < DIGITS; i++) begin
          shown_digits[i] = bcd_t'(rest % 10);
          rest = rest / 10;
        end
        shown_dot = dot;
        loads_stored++;
      end else begin
        res.rejected = 1'b1;
        loads_rejected++;
      end
    end else begin
      // zero dwell behaves like one
      dwell_limit = (dwell_setting == '0) ? 1 : dwell_setting;
      dwell_elapsed++;
      if (dwell_elapsed >= dwell_limit) begin
        dwell_elapsed = 0;
        scan_pos = (scan_pos + 1) % DIGITS;
      end
    end
    res.digit_select = ~(DIGITS'(1) << scan_pos);
    res.bcd_code     = shown_digits[scan_pos];
    res.dot_on       = (int'(shown_dot) == scan_pos);
    return res;
  endfunction

  function automatic void check_field(input string name, input int unsigned expected,
                                      input int unsigned actual);
    if (expected != actual) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, expected, actual);
    end
  endfunction

  // result checker, sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      results_seen++;
      if (display_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result item with nothing pending, expected none, got %h",
                   $time, {out_chan.digit_select, out_chan.bcd_code,
                           out_chan.dot_on, out_chan.rejected});
      end else begin
        oldest_display = display_q.pop_front();
        check_field("digit_select", oldest_display.digit_select, out_chan.digit_select);
        check_field("bcd_code", oldest_display.bcd_code, out_chan.bcd_code);
        check_field("dot_on", oldest_display.dot_on, out_chan.dot_on);
        check_field("rejected", oldest_display.rejected, out_chan.rejected);
      end
    end
  end

  // receiver: random stalls, plus a long hold-off when one is requested
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_len > 0) begin
        out_chan.ready <= 1'b0;
        repeat (hold_len - 1) @(negedge clk);
        hold_len = 0;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // sends one item, called and returning at a falling edge; valid stays
  // high on return so the next item can follow back to back
  task automatic send_item(input mode_t mode, input logic [VALUE_W-1:0] value,
                           input logic [DOT_W-1:0] dot);
    int gap;
    gap = 0;
    while (gap < 200 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.mode      <= mode;
    in_chan.value     <= value;
    in_chan.dot_place <= dot;
    do @(posedge clk); while (!in_chan.ready);
    display_q.push_back(predict_display(mode, value, dot));
    items_sent++;
    @(negedge clk);
  endtask

  // mostly ticks, loads mostly in range, some out of range values
  task automatic send_random_item();
    int               pick;
    logic [VALUE_W-1:0] value;
    logic [DOT_W-1:0]   dot;
    pick = $urandom_range(99);
    dot  = ($urandom_range(3) == 0) ? DOT_W'($urandom_range(7)) : DOT_W'($urandom_range(4));
    if (pick < 60) begin
      send_item(MODE_TICK, VALUE_W'($urandom_range(16383)), DOT_W'($urandom_range(7)));
    end else if (pick < 90) begin
      send_item(MODE_LOAD, VALUE_W'($urandom_range(9999)), dot);
    end else begin
      value = ($urandom_range(1) == 0) ? VALUE_W'($urandom_range(16383, 10000))
                                       : VALUE_W'($urandom_range(16383));
      send_item(MODE_LOAD, value, dot);
    end
  endtask

  // sender pause: stop offering and wait for every pending result
  task automatic wait_for_results();
    in_chan.valid <= 1'b0;
    while (display_q.size() != 0) @(posedge clk);
    // allow the two-stage pipeline to settle
    repeat (4) @(negedge clk);
  endtask

  task automatic apb_write(input logic [CFG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == CFG_IDX_DWELL) begin
      dwell_setting = data[DWELL_W-1:0];
      dwell_writes++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // bus returns to idle before the next transfer
    @(negedge clk);
  endtask

  task automatic apb_read_dwell();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {CFG_IDX_DWELL, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field("dwell_ticks readback", dwell_setting, prdata[DWELL_W-1:0]);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    // bus returns to idle before the next transfer
    @(negedge clk);
  endtask

  // random upper bits on the bus, only the low 16 are kept
  task automatic set_dwell(input logic [DWELL_W-1:0] ticks);
    apb_write(CFG_IDX_DWELL, {16'($urandom), ticks});
  endtask

  // field extremes, rejected values, out of range dot, same value reload
  task automatic test_loads();
    send_item(MODE_TICK, 14'h3fff, 3'd7);   // tick ignores value and dot
    send_item(MODE_LOAD, 14'd0, 3'd0);
    send_item(MODE_LOAD, 14'd9999, 3'd3);
    send_item(MODE_LOAD, 14'd10000, 3'd1);  // first rejected value
    send_item(MODE_LOAD, 14'h3fff, 3'd7);   // all ones, rejected
    send_item(MODE_LOAD, 14'd1234, 3'd5);   // dot past the last digit
    send_item(MODE_LOAD, 14'd1234, 3'd5);   // same value again
    send_item(MODE_LOAD, 14'd8765, 3'd0);
  endtask

  // a load in the middle of a dwell neither advances nor restarts it
  task automatic test_scan_timing();
    send_item(MODE_TICK, 14'd0, 3'd0);
    send_item(MODE_LOAD, 14'd4321, 3'd1);
    send_item(MODE_TICK, 14'h2aaa, 3'd2);   // dwell of 3 reached here
    send_item(MODE_TICK, 14'h1555, 3'd5);
    send_item(MODE_TICK, 14'd0, 3'd0);
    send_item(MODE_TICK, 14'd7, 3'd6);
    send_item(MODE_TICK, 14'd0, 3'd0);
    send_item(MODE_TICK, 14'd0, 3'd0);
  endtask

  // dwell register: unused slot, readback, zero, maximum and minimum
  task automatic test_dwell_register();
    wait_for_results();
    apb_write(CFG_IDX_UNUSED, 32'h0000_0001);  // must leave dwell at 3
    apb_read_dwell();
    set_dwell(16'd0);                          // acts as one tick per digit
    apb_read_dwell();
    repeat (5) send_item(MODE_TICK, 14'd0, 3'd0);
    wait_for_results();
    set_dwell(16'hffff);
    apb_read_dwell();
    repeat (2) send_item(MODE_TICK, 14'd0, 3'd0);
    wait_for_results();
    set_dwell(16'd1);
    send_item(MODE_TICK, 14'd0, 3'd0);
  endtask

  // receiver holds off while the sender keeps offering, input must stall
  task automatic test_backpressure();
    wait_for_results();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_dwell(16'd2);
    hold_len = 300;
    repeat (60) send_random_item();
    wait_for_results();
  endtask

  function automatic logic [DWELL_W-1:0] pick_dwell();
    case ($urandom_range(7))
      0:       return 16'd1;
      1:       return 16'd2;
      2:       return 16'd3;
      3:       return 16'd4;
      4:       return 16'd0;
      5:       return 16'hffff;
      default: return DWELL_W'($urandom_range(8, 1));
    endcase
  endfunction

  // random traffic in chunks, each with its own dwell and a sender pause
  task automatic test_random_traffic(input int idle_pct, input int stall_pct);
    wait_for_results();
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int c = 0; c < CHUNKS; c++) begin
      wait_for_results();
      set_dwell(pick_dwell());
      if ($urandom_range(1) == 0) apb_read_dwell();
      for (int i = 0; i < PHASE_ITEMS / CHUNKS; i++) begin
        if (i == PHASE_ITEMS / CHUNKS / 2) wait_for_results();
        send_random_item();
      end
    end
  endtask

  initial begin
    // every input known from time zero
    rst_n             = 1'b0;
    in_chan.valid     = 1'b0;
    in_chan.mode      = MODE_TICK;
    in_chan.value     = '0;
    in_chan.dot_place = '0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    hold_len          = 0;
    errors            = 0;
    items_sent        = 0;
    results_seen      = 0;
    loads_stored      = 0;
    loads_rejected    = 0;
    dwell_writes      = 0;
    cycle_count       = 0;
    model_reset();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_loads();
    test_scan_timing();
    test_dwell_register();
    test_backpressure();
    test_random_traffic(0, 0);
    test_random_traffic(86, 0);
    test_random_traffic(0, 86);
    test_random_traffic(27, 27);

    wait_for_results();
    repeat (10) @(posedge clk);

    $display("sent %0d items: %0d loads stored, %0d loads refused, rest ticks",
             items_sent, loads_stored, loads_rejected);
    $display("checked %0d results over %0d dwell settings and four idle patterns",
             results_seen, dwell_writes);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/fdds_pkg.sv
rtl/core/fdds_if.sv
rtl/core/fdds_bcd_split.sv
rtl/core/four_digit_display_scanner.sv
dv/four_digit_display_scanner_tb.sv
